// ----- src/rmf_pkg.sv -----
// Shared widths and types of the running median filter.
`default_nettype none

package rmf_pkg;

  localparam int SampleW = 16;
  localparam int HalfW   = 4;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [HalfW-1:0]   half_t;

endpackage : rmf_pkg

`default_nettype wire

// ----- src/running_median_filter.sv -----
// Running median filter over a sliding window of 2k+1 samples, held in two memories.
//
// The window is kept twice: once in arrival order in a circular memory and once
// sorted ascending in a second memory, so the median is the entry at position k.
// Each item takes one removal sweep through the sorted memory per discarded old
// sample, then one insertion sweep, and then the result is handed over. Items are
// handled one at a time: the sweeps run in series through the single read port of
// the sorted memory, and a stall at the output holds the filter. When a short
// sequence ends, its held samples are passed through one at a time in arrival
// order. A new item is accepted while a previous result still waits at the output.
`default_nettype none

module running_median_filter #(
  parameter int MAX_HALF_WINDOW = 15
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [rmf_pkg::HalfW-1:0]   cfg_half_window_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [rmf_pkg::SampleW-1:0] sample_i,
  input  wire                        last_sample_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [rmf_pkg::SampleW-1:0] value_o,
  output logic                       last_result_o
);

  import rmf_pkg::*;

  localparam int Depth = 2 * MAX_HALF_WINDOW + 1;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam half_t MaxHalf = HalfW'(MAX_HALF_WINDOW);
  localparam bit NoClamp = (MAX_HALF_WINDOW >= (2 ** HalfW) - 1);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StDropChk = 4'd1;
  localparam logic [3:0] StRemove  = 4'd2;
  localparam logic [3:0] StInsert  = 4'd3;
  localparam logic [3:0] StDecide  = 4'd4;
  localparam logic [3:0] StMedian  = 4'd5;
  localparam logic [3:0] StPassRd  = 4'd6;
  localparam logic [3:0] StPassOut = 4'd7;

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(Depth)) begin
      s = s - (CW+1)'(Depth);
    end
    return AW'(s);
  endfunction

  // Memories: arrival order and sorted order.
  sample_t fifo_mem [Depth];
  sample_t sort_mem [Depth];

  logic [3:0]    state_q, state_d;
  half_t         half_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pd_addr_q, pd_addr_d;
  logic          found_q, found_d;
  sample_t       smp_q;
  logic          last_q;
  logic          out_valid_q;
  sample_t       out_value_q;
  logic          out_last_q;

  logic          f_we, f_re, s_we, s_re;
  logic [AW-1:0] f_waddr, f_raddr, s_waddr, s_raddr;
  sample_t       f_wdata, s_wdata, f_rdata_q, s_rdata_q;

  logic          out_load;
  sample_t       out_value_d;
  logic          out_last_d;
  logic          out_free;
  logic          rem_done;
  logic          ins_done;

  half_t         k_half;
  logic [AW-1:0] k;
  logic [CW-1:0] win;

  assign k_half = (NoClamp || (half_q <= MaxHalf)) ? half_q : MaxHalf;
  assign k      = AW'(k_half);
  assign win    = CW'({k, 1'b1});

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign last_result_o = out_last_q;
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pd_addr_d   = pd_addr_q;
    found_d     = found_q;
    f_we        = 1'b0;
    f_waddr     = '0;
    f_wdata     = smp_q;
    f_re        = 1'b0;
    f_raddr     = '0;
    s_we        = 1'b0;
    s_waddr     = '0;
    s_wdata     = smp_q;
    s_re        = 1'b0;
    s_raddr     = '0;
    out_load    = 1'b0;
    out_value_d = s_rdata_q;
    out_last_d  = last_q;
    rem_done    = 1'b0;
    ins_done    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StDropChk;
        end
      end
      StDropChk: begin
        ptr_d   = '0;
        found_d = 1'b0;
        if (cnt_q >= win) begin
          f_re    = 1'b1;
          f_raddr = head_q;
          head_d  = addr_add(head_q, CW'(1));
          state_d = StRemove;
        end else begin
          ptr_d   = cnt_q;
          state_d = StInsert;
        end
      end
      StRemove: begin
        // Sweep up the sorted memory, closing the gap left by the discarded sample.
        if (ptr_q < cnt_q) begin
          s_re      = 1'b1;
          s_raddr   = AW'(ptr_q);
          pend_d    = 1'b1;
          pd_addr_d = AW'(ptr_q);
          ptr_d     = ptr_q + CW'(1);
        end
        if (pend_q) begin
          if (found_q) begin
            s_we    = 1'b1;
            s_waddr = pd_addr_q - AW'(1);
            s_wdata = s_rdata_q;
          end else if (s_rdata_q == f_rdata_q) begin
            found_d = 1'b1;
          end
          if (pd_addr_q == AW'(cnt_q - CW'(1))) begin
            rem_done = 1'b1;
            pend_d   = 1'b0;
            cnt_d    = cnt_q - CW'(1);
            state_d  = StDropChk;
          end
        end
      end
      StInsert: begin
        // Sweep down the sorted memory, shifting larger entries up by one.
        if (ptr_q != '0) begin
          s_re      = 1'b1;
          s_raddr   = AW'(ptr_q - CW'(1));
          pend_d    = 1'b1;
          pd_addr_d = AW'(ptr_q - CW'(1));
          ptr_d     = ptr_q - CW'(1);
        end
        if (pend_q) begin
          s_we    = 1'b1;
          s_waddr = pd_addr_q + AW'(1);
          if (s_rdata_q > smp_q) begin
            s_wdata = s_rdata_q;
          end else begin
            s_wdata  = smp_q;
            ins_done = 1'b1;
          end
        end else if (ptr_q == '0) begin
          s_we     = 1'b1;
          s_waddr  = '0;
          s_wdata  = smp_q;
          ins_done = 1'b1;
        end
        if (ins_done) begin
          pend_d  = 1'b0;
          f_we    = 1'b1;
          f_waddr = addr_add(head_q, cnt_q);
          cnt_d   = cnt_q + CW'(1);
          state_d = StDecide;
        end
      end
      StDecide: begin
        ptr_d = '0;
        if (cnt_q == win) begin
          s_re    = 1'b1;
          s_raddr = k;
          state_d = StMedian;
        end else if (last_q) begin
          state_d = StPassRd;
        end else begin
          state_d = StIdle;
        end
      end
      StMedian: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = s_rdata_q;
          out_last_d  = last_q;
          if (last_q) begin
            cnt_d = '0;
          end
          state_d = StIdle;
        end
      end
      StPassRd: begin
        f_re    = 1'b1;
        f_raddr = addr_add(head_q, ptr_q);
        state_d = StPassOut;
      end
      StPassOut: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = f_rdata_q;
          out_last_d  = (ptr_q == cnt_q - CW'(1));
          ptr_d       = ptr_q + CW'(1);
          if (out_last_d) begin
            cnt_d   = '0;
            state_d = StIdle;
          end else begin
            state_d = StPassRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      half_q      <= half_t'(1);
      cnt_q       <= '0;
      head_q      <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      pd_addr_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      pd_addr_q <= pd_addr_d;
      found_q   <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        half_q <= cfg_half_window_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q  <= sample_i;
      last_q <= last_sample_i;
    end
    if (out_load) begin
      out_value_q <= out_value_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      fifo_mem[f_waddr] <= f_wdata;
    end
    if (f_re) begin
      f_rdata_q <= fifo_mem[f_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      sort_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= sort_mem[s_raddr];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(Depth))
    else $error("Sample count exceeds the store depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (found_q || (s_rdata_q == f_rdata_q)))
    else $error("Discarded sample was not found in the sorted memory.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ins_done |-> (cnt_q < win))
    else $error("Insertion into a full window.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("Result overwrote an item not yet taken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_we && s_re) |-> (s_waddr != s_raddr))
    else $error("Sorted memory read and written at the same entry.");

endmodule : running_median_filter

`default_nettype wire
